FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Depends on nothing; each file that asserts includes it by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property sampled on the rising clock edge, switched off while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The same, written as an overlapping implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

FILE: rtl/core/ntst_pkg.sv
// Package for the name to socket table: sizes, entry layout and codes.
// Used by the table unit and its checker; depends on nothing.
package ntst_pkg;

  localparam int CAPACITY = 128;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int OP_W           = 2;
  localparam int WORD_W         = 64;
  localparam int HIGH_W         = 32;
  localparam int SOCK_W         = 16;
  localparam int STATUS_W       = 2;
  localparam int POS_W          = 7;
  localparam int ENTRY_CNT_W    = 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] key_low;
    logic [WORD_W-1:0] key_mid;
    logic [HIGH_W-1:0] key_high;
    logic [SOCK_W-1:0] socket;
  } entry_t;

endpackage

FILE: rtl/core/name_to_socket_table_unit.sv
// Insert and the unused code go from acceptance to S_FINISH, which fills the output
// word once the output register is free. Lookup and remove walk the entry memory
// at one read a cycle and a lookup that hits stops early. One word is in work at a time;
// a finished word may wait in the output register while the next is accepted.
// Reset (rst_n, synchronous) clears the count, the controller and the output
// valid; the entry memory is not cleared, as only entries below the count are read.
module name_to_socket_table_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ntst_pkg::OP_W-1:0]         in_operation,
  input  logic [ntst_pkg::WORD_W-1:0]       in_name_word0,
  input  logic [ntst_pkg::WORD_W-1:0]       in_name_word1,
  input  logic [ntst_pkg::HIGH_W-1:0]       in_name_word2,
  input  logic [ntst_pkg::SOCK_W-1:0]       in_socket_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ntst_pkg::STATUS_W-1:0]     out_status,
  output logic [ntst_pkg::SOCK_W-1:0]       out_found_socket,
  output logic [ntst_pkg::POS_W-1:0]        out_found_position,
  output logic [ntst_pkg::ENTRY_CNT_W-1:0]  out_entry_count
);
  import ntst_pkg::*;

  entry_t mem [0:CAPACITY-1];

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [WORD_W-1:0] key_low_r, key_low_nxt;
  logic [WORD_W-1:0] key_mid_r, key_mid_nxt;
  logic [HIGH_W-1:0] key_high_r, key_high_nxt;
  logic              full_r, full_nxt;
  logic              found_r, found_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [SOCK_W-1:0] fsock_r, fsock_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  entry_t            rd_data_r;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;
  logic              hit;

  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [SOCK_W-1:0]      out_sock_r, out_sock_nxt;
  logic [POS_W-1:0]       out_pos_r, out_pos_nxt;
  logic [ENTRY_CNT_W-1:0] out_cnt_r, out_cnt_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign hit = (rd_data_r.key_low == key_low_r) && (rd_data_r.key_mid == key_mid_r) &&
               (rd_data_r.key_high == key_high_r);

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    key_low_nxt  = key_low_r;
    key_mid_nxt  = key_mid_r;
    key_high_nxt = key_high_r;
    full_nxt     = full_r;
    found_nxt    = found_r;
    pos_nxt      = pos_r;
    fsock_nxt    = fsock_r;
    count_nxt    = count_r;
    issue_nxt    = issue_r;
    rd_vld_nxt   = rd_vld_r;
    rd_idx_nxt   = rd_idx_r;
    rd_en        = 1'b0;
    rd_addr      = issue_r[ADDR_W-1:0];
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = rd_data_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_sock_nxt   = out_sock_r;
    out_pos_nxt    = out_pos_r;
    out_cnt_nxt    = out_cnt_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = op_t'(in_operation);
          key_low_nxt  = in_name_word0;
          key_mid_nxt  = in_name_word1;
          key_high_nxt = in_name_word2;
          full_nxt     = 1'b0;
          found_nxt    = 1'b0;
          pos_nxt      = '0;
          fsock_nxt    = '0;
          issue_nxt    = '0;
          rd_vld_nxt   = 1'b0;
          case (op_t'(in_operation))
            OP_INSERT: begin
              if (count_r >= CNT_W'(CAPACITY)) begin
                full_nxt = 1'b1;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = count_r[ADDR_W-1:0];
                wr_data   = '{key_low: in_name_word0, key_mid: in_name_word1,
                              key_high: in_name_word2, socket: in_socket_value};
                count_nxt = count_r + 1'b1;
              end
              state_nxt = S_FINISH;
            end
            OP_LOOKUP, OP_REMOVE: begin
              state_nxt = S_SCAN;
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Each read is registered; the compare works on the returned entry in the cycle after its issue.
        rd_vld_nxt = 1'b0;
        if (issue_r < count_r) begin
          rd_en      = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = issue_r[ADDR_W-1:0];
          issue_nxt  = issue_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (!found_r && hit) begin
            found_nxt = 1'b1;
            pos_nxt   = rd_idx_r;
            fsock_nxt = rd_data_r.socket;
            if (op_r == OP_LOOKUP) begin
              state_nxt = S_FINISH;
            end
          end else if (found_r) begin
            // Entries after the removed one move down by one place as they stream by.
            wr_en   = 1'b1;
            wr_addr = rd_idx_r - 1'b1;
          end
        end
        if (!rd_vld_r && (issue_r >= count_r)) begin
          state_nxt = S_FINISH;
          if (found_r) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_sock_nxt   = '0;
          out_pos_nxt    = '0;
          out_cnt_nxt    = ENTRY_CNT_W'(count_r);
          case (op_r)
            OP_INSERT: begin
              if (full_r) begin
                out_status_nxt = ST_FULL;
              end
            end
            OP_LOOKUP: begin
              if (found_r) begin
                out_sock_nxt = fsock_r;
                out_pos_nxt  = POS_W'(pos_r);
              end else begin
                out_status_nxt = ST_NOTFOUND;
              end
            end
            OP_REMOVE: begin
              if (!found_r) begin
                out_status_nxt = ST_NOTFOUND;
              end
            end
            default: begin
              out_status_nxt = ST_OK;
            end
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_low_r    <= key_low_nxt;
    key_mid_r    <= key_mid_nxt;
    key_high_r   <= key_high_nxt;
    full_r       <= full_nxt;
    found_r      <= found_nxt;
    pos_r        <= pos_nxt;
    fsock_r      <= fsock_nxt;
    issue_r      <= issue_nxt;
    rd_idx_r     <= rd_idx_nxt;
    out_status_r <= out_status_nxt;
    out_sock_r   <= out_sock_nxt;
    out_pos_r    <= out_pos_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_socket   = out_sock_r;
  assign out_found_position = out_pos_r;
  assign out_entry_count    = out_cnt_r;

endmodule

FILE: rtl/core/ntst_checker.sv
// Port-level checker for the name to socket table unit, with its bind.
// Depends on ntst_pkg and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module ntst_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [ntst_pkg::STATUS_W-1:0]     out_status,
  input logic [ntst_pkg::SOCK_W-1:0]       out_found_socket,
  input logic [ntst_pkg::POS_W-1:0]        out_found_position,
  input logic [ntst_pkg::ENTRY_CNT_W-1:0]  out_entry_count
);
  import ntst_pkg::*;

  // A stalled result word stays and keeps its status, socket and entry count.
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_found_socket) && $stable(out_entry_count), "stalled result word changed")

  // Once a word is taken in, the unit is busy in the next cycle.
  `ASSERT_CLK(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall, "input accepted twice in a row")

  `ASSERT_IMPLIES(a_full_count, clk, rst_n, out_valid && (out_status == ST_FULL), out_entry_count == ENTRY_CNT_W'(CAPACITY), "full reported below capacity")

  `ASSERT_IMPLIES(a_miss_zero, clk, rst_n, out_valid && (out_status != ST_OK), (out_found_socket == '0) && (out_found_position == '0), "failed request carries a position")

endmodule

bind name_to_socket_table_unit ntst_checker u_ntst_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_found_socket   (out_found_socket),
  .out_found_position (out_found_position),
  .out_entry_count    (out_entry_count)
);
